// File: design/ptg_pkg.sv
// Shared types and constants for the PC speaker tone generator.
// No dependencies; every other design file imports this package.
package ptg_pkg;

	// Input function codes
	localparam logic [2:0] FUNC_CTRL     = 3'd0;
	localparam logic [2:0] FUNC_CH2_DATA = 3'd1;
	localparam logic [2:0] FUNC_PORT_WR  = 3'd2;
	localparam logic [2:0] FUNC_PORT_RD  = 3'd3;
	localparam logic [2:0] FUNC_TICK     = 3'd4;

	// Configuration register indexes
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LP_COEFF   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = 2'd2;

	localparam logic [23:0] PHASE_STEP_RST = 24'd1773161;
	localparam logic [15:0] LP_COEFF_RST   = 16'd22938;
	localparam logic [14:0] AMPLITUDE_RST  = 15'd7000;

	// Timer control word: select field must read channel 2
	localparam logic [7:0] CTRL_SEL_MASK = 8'hC0;
	localparam logic [7:0] CTRL_SEL_CH2  = 8'h80;

	// Speaker port bits
	localparam int PORT_GATE_BIT = 0;
	localparam int PORT_DATA_BIT = 1;

	// Shift-add multiplier: multiplier operand is 16 bits, one bit per cycle
	localparam int MUL_STEPS = 16;
	localparam int MUL_CNT_W = 4;
	localparam int COEFF_FRAC = 16;

	localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [15:0] SAMPLE_MIN = -16'sh8000;

	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_RUN,
		TOP_HOLD
	} top_state_t;

	typedef enum logic [2:0] {
		FLT_IDLE,
		FLT_MUL1,
		FLT_UPD,
		FLT_PREP,
		FLT_MUL2,
		FLT_OUT
	} flt_state_t;

	typedef struct packed {
		logic start;
		logic target_high;
	} flt_cmd_t;

	typedef struct packed {
		logic               sample_valid;
		logic signed [15:0] sample;
		logic [15:0]        divisor;
		logic [7:0]         port_b;
	} res_t;

endpackage

// File: design/ptg_phase.sv
// Timer channel 2 phase accumulator with a bit-serial restoring remainder unit.
// Depends on ptg_pkg.
module ptg_phase import ptg_pkg::*; #(
	parameter int PHASE_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] phase_step,
	input  logic [15:0] reload,
	output logic        busy,
	output logic        wave_high
);

	localparam int PW = 17 + PHASE_FRAC_BITS;	// period and accumulator width
	localparam int CW = $clog2(PW + 1);

	logic [16:0]   div_ext;
	logic [PW-1:0] period;
	logic [PW-1:0] phase_q;
	logic [PW-1:0] x_q;
	logic [PW-1:0] per_q;
	logic [PW-1:0] r_q;
	logic [PW-1:0] r_sh;
	logic [PW-1:0] r_nx;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	assign div_ext = (reload == 16'd0) ? 17'h10000 : {1'b0, reload};
	assign period  = {div_ext, {PHASE_FRAC_BITS{1'b0}}};

	// High half of the period
	assign wave_high = {phase_q, 1'b0} < {1'b0, period};

	// Shift in the next dividend bit, subtract the period when it fits
	assign r_sh = {r_q[PW-2:0], x_q[PW-1]};
	assign r_nx = (r_sh >= per_q) ? (r_sh - per_q) : r_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			phase_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(PW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q  <= 1'b0;
				phase_q <= r_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= phase_q + PW'(phase_step);
			per_q <= period;
			r_q   <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[PW-2:0], 1'b0};
			r_q <= r_nx;
		end
	end

	assign busy = busy_q;

endmodule

// File: design/ptg_filter.sv
// One-pole speaker low-pass and amplitude scaling on a shared shift-add multiplier.
// Depends on ptg_pkg.
module ptg_filter import ptg_pkg::*; #(
	parameter int FILTER_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  flt_cmd_t           cmd,
	input  logic [15:0]        coeff,
	input  logic [14:0]        amp,
	output logic               busy,
	output logic signed [15:0] sample
);

	localparam int LW = FILTER_BITS;
	localparam int MW = FILTER_BITS + 1;
	localparam int AW = FILTER_BITS + 17;
	localparam logic [MW-1:0] FULL = {1'b1, {LW{1'b0}}};
	localparam logic [LW-1:0] LMAX = {LW{1'b1}};
	localparam logic [AW-1:0] RND  = AW'(1) << (COEFF_FRAC - 1);
	localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_STEPS - 1);

	flt_state_t          state_q, state_d;
	logic [LW-1:0]       level_q;
	logic [AW-1:0]       acc_q;
	logic [AW-1:0]       acc_nx;
	logic [15:0]         mr_q;
	logic [MW-1:0]       mcand_q;
	logic                up_q;
	logic                neg_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic signed [15:0]  sample_q;

	logic [AW-1:0] rnd;
	logic [MW-1:0] step;
	logic [MW:0]   sum_up;
	logic [LW-1:0] y_up;
	logic [LW-1:0] y_dn;
	logic [MW-1:0] twice;
	logic [MW-1:0] m_mag;
	logic          m_neg;
	logic [15:0]   qm;
	logic signed [15:0] q;

	assign acc_nx = {acc_q[AW-2:0], 1'b0} + (mr_q[15] ? AW'(mcand_q) : '0);

	// Round half up, then apply toward the target and clamp to the level range
	assign rnd    = acc_q + RND;
	assign step   = rnd[AW-1:COEFF_FRAC];
	assign sum_up = (MW+1)'(level_q) + (MW+1)'(step);
	assign y_up   = (sum_up > (MW+1)'(LMAX)) ? LMAX : sum_up[LW-1:0];
	assign y_dn   = (step > MW'(level_q)) ? '0 : (level_q - step[LW-1:0]);

	// Signed level 2*y - full as sign and magnitude
	assign twice = {level_q, 1'b0};
	always_comb begin
		if (twice >= FULL) begin
			m_mag = twice - FULL;
			m_neg = 1'b0;
		end else begin
			m_mag = FULL - twice;
			m_neg = 1'b1;
		end
	end

	assign qm = acc_q[FILTER_BITS+15:FILTER_BITS];
	always_comb begin
		if (!neg_q) begin
			q = (qm > 16'd32767) ? SAMPLE_MAX : $signed(qm);
		end else begin
			q = (qm > 16'd32768) ? SAMPLE_MIN : $signed(-qm);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FLT_IDLE: begin
				if (cmd.start) state_d = FLT_MUL1;
			end
			FLT_MUL1: begin
				if (cnt_q == MUL_LAST) state_d = FLT_UPD;
			end
			FLT_UPD:  state_d = FLT_PREP;
			FLT_PREP: state_d = FLT_MUL2;
			FLT_MUL2: begin
				if (cnt_q == MUL_LAST) state_d = FLT_OUT;
			end
			FLT_OUT:  state_d = FLT_IDLE;
			default:  state_d = FLT_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FLT_IDLE;
			level_q <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FLT_MUL1 || state_q == FLT_MUL2) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (state_q == FLT_UPD) level_q <= up_q ? y_up : y_dn;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			FLT_IDLE: begin
				if (cmd.start) begin
					mcand_q <= cmd.target_high ? (FULL - MW'(level_q)) : MW'(level_q);
					up_q    <= cmd.target_high;
					mr_q    <= coeff;
					acc_q   <= '0;
				end
			end
			FLT_MUL1, FLT_MUL2: begin
				acc_q <= acc_nx;
				mr_q  <= {mr_q[14:0], 1'b0};
			end
			FLT_PREP: begin
				mcand_q <= m_mag;
				neg_q   <= m_neg;
				mr_q    <= {1'b0, amp};
				acc_q   <= '0;
			end
			FLT_OUT:  sample_q <= q;
			default: ;
		endcase
	end

	assign busy   = (state_q != FLT_IDLE);
	assign sample = sample_q;

endmodule

// File: design/pc_speaker_tone_generator_top.sv
// PC speaker tone generator: timer channel 2 registers, speaker port and result queue.
// Depends on ptg_pkg, ptg_phase and ptg_filter.
//
// Usage: one input beat (func, data_byte) on in_valid/in_ready gives one result beat
// on out_valid/out_ready. Timer control, channel 2 data, port write and port read
// beats update state at acceptance and their result is registered in the output
// register when it is free. A sample tick starts two serial units at once: the phase
// remainder, one dividend bit per cycle over its 17 + PHASE_FRAC_BITS dividend bits, and
// the low-pass, whose shared shift-add multiplier makes one pass for the filter
// step and one for amplitude scaling. A tick result is parked in the hold register
// once both units finish, which the filter's two multiply passes decide, and no new
// item is taken until it has moved to the output register.
// The block takes a new item while an earlier result waits in the output register;
// if a further result finds that register still full it is parked in a hold register
// and input stalls until the receiver drains a beat.
// Reset (arst_n low) returns the configuration registers to their defaults and
// clears the divisor, port byte, phase and filter level. Configuration writes on
// cfg_we/cfg_index/cfg_data take effect at once; an index beyond the list is dropped.
module pc_speaker_tone_generator_top import ptg_pkg::*; #(
	parameter int PHASE_FRAC_BITS = 16,
	parameter int FILTER_BITS     = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           func,
	input  logic [7:0]           data_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 sample_valid,
	output logic signed [15:0]   sample,
	output logic [15:0]          divisor_now,
	output logic [7:0]           port_b_value
);

	top_state_t state_q, state_d;

	logic [23:0] phase_step_q;
	logic [15:0] lp_coeff_q;
	logic [14:0] amplitude_q;

	logic        hi_q, hi_nx;
	logic [7:0]  lo_q, lo_nx;
	logic [15:0] reload_q, reload_nx;
	logic [7:0]  port_b_q, port_b_nx;

	logic        fire;
	logic        is_tick;
	logic        out_free;
	logic        units_done;
	logic        ph_busy;
	logic        ph_wave;
	logic        flt_busy;
	logic signed [15:0] flt_sample;
	flt_cmd_t    flt_cmd;

	res_t res_now;
	res_t res_tick;
	res_t hold_q;
	res_t out_q;
	logic out_valid_q;

	assign in_ready   = (state_q == TOP_IDLE);
	assign fire       = in_valid && in_ready;
	assign is_tick    = (func == FUNC_TICK);
	assign out_free   = !out_valid_q || out_ready;
	assign units_done = !ph_busy && !flt_busy;

	// Level target: data bit clear gives 0, gate clear gives 1, else the square wave
	assign flt_cmd.start       = fire && is_tick;
	assign flt_cmd.target_high = port_b_q[PORT_DATA_BIT] && (!port_b_q[PORT_GATE_BIT] || ph_wave);

	ptg_phase #(
		.PHASE_FRAC_BITS(PHASE_FRAC_BITS)
	) u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (flt_cmd.start),
		.phase_step(phase_step_q),
		.reload    (reload_q),
		.busy      (ph_busy),
		.wave_high (ph_wave)
	);

	ptg_filter #(
		.FILTER_BITS(FILTER_BITS)
	) u_filter (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (flt_cmd),
		.coeff (lp_coeff_q),
		.amp   (amplitude_q),
		.busy  (flt_busy),
		.sample(flt_sample)
	);

	// Decode writes into the next timer and port state
	always_comb begin
		hi_nx     = hi_q;
		lo_nx     = lo_q;
		reload_nx = reload_q;
		port_b_nx = port_b_q;
		unique case (func)
			FUNC_CTRL: begin
				if ((data_byte & CTRL_SEL_MASK) == CTRL_SEL_CH2) hi_nx = 1'b0;
			end
			FUNC_CH2_DATA: begin
				if (!hi_q) begin
					lo_nx = data_byte;
					hi_nx = 1'b1;
				end else begin
					reload_nx = {data_byte, lo_q};
					hi_nx     = 1'b0;
				end
			end
			FUNC_PORT_WR: port_b_nx = data_byte;
			default: ;
		endcase
	end

	always_comb begin
		res_now.sample_valid = 1'b0;
		res_now.sample       = '0;
		res_now.divisor      = reload_nx;
		res_now.port_b       = port_b_nx;

		res_tick.sample_valid = 1'b1;
		res_tick.sample       = flt_sample;
		res_tick.divisor      = reload_q;
		res_tick.port_b       = port_b_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TOP_IDLE: begin
				if (fire && is_tick) begin
					state_d = TOP_RUN;
				end else if (fire && !out_free) begin
					state_d = TOP_HOLD;
				end
			end
			TOP_RUN: begin
				if (units_done) state_d = TOP_HOLD;
			end
			TOP_HOLD: begin
				if (out_free) state_d = TOP_IDLE;
			end
			default: state_d = TOP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= TOP_IDLE;
			phase_step_q <= PHASE_STEP_RST;
			lp_coeff_q   <= LP_COEFF_RST;
			amplitude_q  <= AMPLITUDE_RST;
			hi_q         <= 1'b0;
			lo_q         <= '0;
			reload_q     <= '0;
			port_b_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PHASE_STEP: phase_step_q <= cfg_data[23:0];
					REG_LP_COEFF:   lp_coeff_q   <= cfg_data[15:0];
					REG_AMPLITUDE:  amplitude_q  <= cfg_data[14:0];
					default: ;
				endcase
			end
			if (fire) begin
				hi_q     <= hi_nx;
				lo_q     <= lo_nx;
				reload_q <= reload_nx;
				port_b_q <= port_b_nx;
			end
			if ((fire && !is_tick && out_free) || (state_q == TOP_HOLD && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output beat and parked result
	always_ff @(posedge clk) begin
		if (fire && !is_tick && out_free) begin
			out_q <= res_now;
		end else if (state_q == TOP_HOLD && out_free) begin
			out_q <= hold_q;
		end
		if (fire && !is_tick && !out_free) begin
			hold_q <= res_now;
		end else if (state_q == TOP_RUN && units_done) begin
			hold_q <= res_tick;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_valid = out_q.sample_valid;
	assign sample       = out_q.sample;
	assign divisor_now  = out_q.divisor;
	assign port_b_value = out_q.port_b;

	a_units_start_together: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ph_busy) |-> flt_busy)
		else $error("phase unit started without the filter");

	a_idle_units_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == TOP_IDLE) |-> (!ph_busy && !flt_busy))
		else $error("serial unit busy while control is idle");

	a_tick_enters_run: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_tick) |=> (state_q == TOP_RUN))
		else $error("sample tick did not start a run");

	a_status_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.sample_valid) |-> (out_q.sample == 16'sd0))
		else $error("status beat carries a nonzero sample");

endmodule
